### sv/scrambled_truth_table_lookup_top_macros.svh
// Assertion macros shared by the checker of the truth table lookup block.
`ifndef SCRAMBLED_TRUTH_TABLE_LOOKUP_TOP_MACROS_SVH
`define SCRAMBLED_TRUTH_TABLE_LOOKUP_TOP_MACROS_SVH

// Property sampled on clk, ignored while rst is high.
`define STTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on clk at every edge, reset included.
`define STTL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/sttl_pkg.sv
// Shared constants and controller/datapath interface types of the lookup block.
`default_nettype none
package sttl_pkg;

  // Default sizes of the table and words
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int INPUT_BITS_DEF  = 16;
  localparam int OUTPUT_BITS_DEF = 16;

  // Port widths fixed by the item format
  localparam int KEY_W     = 16;
  localparam int COUNT_W   = 9;
  localparam int INDEX_W   = 8;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_KEY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_KEY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd2;

  // Request opcodes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic write_entry;  // store the request's words at its index
    logic start;        // latch unscrambled query and open the search range
    logic probe_mid;    // address the table at the range midpoint
    logic step;         // narrow the range from the probed word
    logic take_match;   // record the final compare
    logic clear_res;    // record a miss
    logic push;         // load the result into the output register
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic dead;      // search range is empty
    logic multi;     // range holds more than one entry
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage
`default_nettype wire

### sv/scrambled_truth_table_lookup_top.sv
// Top level of the scrambled truth table lookup block.
// A write request stores an input word and output word at a table position and
// returns nothing. A lookup request XORs its words with the input and output
// keys, binary-searches the first entry_count entries (clamped to the table
// depth) and returns found. Each probe addresses the single-port table RAM at
// the range midpoint in ST_EVAL and narrows the range in ST_STEP from the
// registered read data; a single remaining entry is read and compared in
// ST_FINAL, and the result waits in ST_DONE until the output register is free.
// A lookup holds off further requests until its result is pushed. A new request
// is taken while a previous result waits in the output register. The table holds
// no valid bits: entries must be written before a lookup can reach them.
// Configuration may be written only while idle.
`default_nettype none
module scrambled_truth_table_lookup_top import sttl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int INPUT_BITS  = INPUT_BITS_DEF,
  parameter int OUTPUT_BITS = OUTPUT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 cmd,
  input  wire logic [INDEX_W-1:0]   index,
  input  wire logic [KEY_W-1:0]     entry_inputs,
  input  wire logic [KEY_W-1:0]     entry_outputs,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      found,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_data
);

  ctl_t ctl;
  sts_t sts;

  sttl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd     (cmd),
    .sts     (sts),
    .ctl     (ctl)
  );

  sttl_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INPUT_BITS (INPUT_BITS),
    .OUTPUT_BITS(OUTPUT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .index        (index),
    .entry_inputs (entry_inputs),
    .entry_outputs(entry_outputs),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .ctl          (ctl),
    .sts          (sts)
  );

endmodule
`default_nettype wire

### sv/sttl_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module sttl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, read the addressed word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### sv/sttl_datapath.sv
// Datapath: configuration registers, table RAM, search range and output register.
`default_nettype none
module sttl_datapath import sttl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int INPUT_BITS  = INPUT_BITS_DEF,
  parameter int OUTPUT_BITS = OUTPUT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_data,
  input  wire logic [INDEX_W-1:0]   index,
  input  wire logic [KEY_W-1:0]     entry_inputs,
  input  wire logic [KEY_W-1:0]     entry_outputs,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      found,
  input  wire ctl_t                 ctl,
  output sts_t                      sts
);

  localparam int IW    = INPUT_BITS;
  localparam int OW    = (OUTPUT_BITS > 16) ? 16 : OUTPUT_BITS;
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [IW-1:0]      input_key;
  logic [OW-1:0]      output_key;
  logic [COUNT_W-1:0] entry_count;
  logic [IW-1:0]      q_in;
  logic [OW-1:0]      q_out;
  logic [AW-1:0]      lo;
  logic [AW-1:0]      hi;
  logic               dead;
  logic               res;

  logic [EW-1:0]      cnt_ext;
  logic [EW-1:0]      cnt_eff;
  logic [AW:0]        sum;
  logic [AW-1:0]      mid;
  logic [AW-1:0]      wr_addr;
  logic               wr_in_range;
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [IW+OW-1:0]   ram_wdata;
  logic [IW+OW-1:0]   ram_rdata;
  logic [IW-1:0]      probe_in;
  logic [OW-1:0]      probe_out;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_key   <= '0;
      output_key  <= '0;
      entry_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_INPUT_KEY:   input_key   <= cfg_data[IW-1:0];
        REG_OUTPUT_KEY:  output_key  <= cfg_data[OW-1:0];
        REG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the entry count to the table depth
  assign cnt_ext = EW'(entry_count);
  assign cnt_eff = (cnt_ext > EW'(TABLE_DEPTH)) ? EW'(TABLE_DEPTH) : cnt_ext;

  // Midpoint of the remaining range, rounding down
  assign sum = {1'b0, lo} + {1'b0, hi};
  assign mid = sum[AW:1];

  // Table write address and range check
  assign wr_in_range = (32'(index) < 32'(TABLE_DEPTH));
  assign wr_addr     = AW'(index);

  // Table port: write in idle, read midpoint or final position otherwise
  always_comb begin
    if (ctl.write_entry) begin
      ram_addr = wr_addr;
    end else if (ctl.probe_mid) begin
      ram_addr = mid;
    end else begin
      ram_addr = lo;
    end
  end
  assign ram_we    = ctl.write_entry & wr_in_range;
  assign ram_wdata = {entry_outputs[OW-1:0], entry_inputs[IW-1:0]};

  sttl_ram #(
    .WIDTH(IW + OW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign probe_in  = ram_rdata[IW-1:0];
  assign probe_out = ram_rdata[IW+OW-1:IW];

  // Unscramble the query, open and narrow the search range
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_in  <= entry_inputs[IW-1:0] ^ input_key;
      q_out <= entry_outputs[OW-1:0] ^ output_key;
      lo    <= '0;
      hi    <= AW'(cnt_eff - EW'(1));
      dead  <= (cnt_eff == '0);
    end else if (ctl.step) begin
      if (probe_in > q_in) begin
        if (mid == lo) begin
          dead <= 1'b1;
        end else begin
          hi <= mid - AW'(1);
        end
      end else if (probe_in < q_in) begin
        lo <= mid + AW'(1);
      end else begin
        lo <= mid;
        hi <= mid;
      end
    end
  end

  // Record the search outcome
  always_ff @(posedge clk) begin
    if (ctl.take_match) begin
      res <= (probe_in == q_in) && (probe_out == q_out);
    end else if (ctl.clear_res) begin
      res <= 1'b0;
    end
  end

  // Output register: load on push, drop on acceptance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      found <= res;
    end
  end

  assign sts.dead     = dead;
  assign sts.multi    = (hi > lo);
  assign sts.out_free = ~out_valid | out_ready;

endmodule
`default_nettype wire

### sv/sttl_ctrl.sv
// Controller: sequences table writes and the probes of a binary search.
`default_nettype none
module sttl_ctrl import sttl_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic cmd,
  input  wire sts_t sts,
  output ctl_t      ctl
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Decode state into datapath commands
  always_comb begin
    ctl        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cmd == CMD_WRITE) begin
            ctl.write_entry = 1'b1;
          end else begin
            ctl.start  = 1'b1;
            state_next = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (sts.dead) begin
          ctl.clear_res = 1'b1;
          state_next    = ST_DONE;
        end else if (sts.multi) begin
          ctl.probe_mid = 1'b1;
          state_next    = ST_STEP;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_STEP: begin
        ctl.step   = 1'b1;
        state_next = ST_EVAL;
      end
      ST_FINAL: begin
        ctl.take_match = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### sv/sttl_checker.sv
// Port-level checker of the lookup block and its bind to the top level.
`default_nettype none
`include "scrambled_truth_table_lookup_top_macros.svh"
module sttl_checker import sttl_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 cmd,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 found
);

  // A stalled result holds
  `STTL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(found), "result dropped or changed while stalled")

  // Reset empties the output register
  `STTL_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result present after reset")

  // A write request never produces a result
  `STTL_ASSERT(a_write_silent, in_valid && in_ready && cmd == CMD_WRITE && !out_valid |=> !out_valid, "write request produced a result")

  // A lookup makes the block busy: in_ready is low in the cycle after it is taken
  `STTL_ASSERT(a_lookup_busy, in_valid && in_ready && cmd == CMD_LOOKUP |=> !in_ready, "new request taken right after a lookup")

endmodule

bind scrambled_truth_table_lookup_top sttl_checker u_sttl_checker (.*);
`default_nettype wire
